@@ hdl/vertex_transform_project_cull_assert.svh @@
// Assertion helpers shared by the RTL.
`ifndef VERTEX_TRANSFORM_PROJECT_CULL_ASSERT_SVH
`define VERTEX_TRANSFORM_PROJECT_CULL_ASSERT_SVH

`define VTPC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

`define VTPC_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) else $error(msg);

`endif

@@ hdl/vtpc_pkg.sv @@
`default_nettype none
package vtpc_pkg;

    localparam logic [2:0] CFG_OFFSET_X     = 3'd0;
    localparam logic [2:0] CFG_OFFSET_Y     = 3'd1;
    localparam logic [2:0] CFG_OFFSET_Z     = 3'd2;
    localparam logic [2:0] CFG_MODEL_YAW    = 3'd3;
    localparam logic [2:0] CFG_CAMERA_YAW   = 3'd4;
    localparam logic [2:0] CFG_CAMERA_PITCH = 3'd5;
    localparam logic [2:0] CFG_CULL_ENABLE  = 3'd6;

    localparam logic [31:0] FOCAL_FIX = 32'h00DC_0000;
    localparam logic signed [31:0] NEAR_Z = 32'sd32768;
    localparam int DIV_BITS = 48;

    localparam logic [15:0] QSINE [64] = '{
        16'd0, 16'd804, 16'd1608, 16'd2410, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
        16'd6393, 16'd7179, 16'd7962, 16'd8739, 16'd9512, 16'd10278, 16'd11039, 16'd11793,
        16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846,
        16'd17530, 16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403,
        16'd22005, 16'd22594, 16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329,
        16'd25832, 16'd26319, 16'd26790, 16'd27245, 16'd27683, 16'd28105, 16'd28510,
        16'd28898, 16'd29268, 16'd29621, 16'd29956, 16'd30273, 16'd30571, 16'd30852,
        16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971, 16'd32137, 16'd32285,
        16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757
    };

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic [15:0]        tri_color;
    } t_in;

    typedef struct packed {
        logic signed [15:0] screen_x0;
        logic signed [15:0] screen_y0;
        logic signed [15:0] screen_x1;
        logic signed [15:0] screen_y1;
        logic signed [15:0] screen_x2;
        logic signed [15:0] screen_y2;
        logic               visible;
        logic [15:0]        out_color;
    } t_out;

    typedef struct packed {
        logic [31:0] offset_x;
        logic [31:0] offset_y;
        logic [31:0] offset_z;
        logic [7:0]  model_yaw;
        logic [7:0]  camera_yaw;
        logic [7:0]  camera_pitch;
        logic        cull_enable;
    } t_cfg;

    function automatic logic [31:0] sine16(input logic [7:0] ang);
        logic [5:0]  p;
        logic [31:0] v;
        p = ang[6] ? (6'd63 - ang[5:0]) : ang[5:0];
        v = {15'd0, QSINE[p], 1'b0};
        return ang[7] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] cosine16(input logic [7:0] ang);
        return sine16(ang + 8'd64);
    endfunction

endpackage
`default_nettype wire

@@ hdl/vertex_transform_project_cull.sv @@
// channel   | valid       | ready       | payload
// ----------+-------------+-------------+-----------------------------
// input     | i_in_valid  | o_in_ready  | i_in_data  (vtpc_pkg::t_in)
// output    | o_out_valid | i_out_ready | o_out_data (vtpc_pkg::t_out)
// config    | i_cfg_wr_en | -           | i_cfg_index, i_cfg_data
//
// The back end takes a new triangle only once it is through with the last one: it takes
// it from the queue, then per vertex runs 14 steps of the shared 32x32 multiplier,
// starts the divider, waits on the one-bit-a-cycle divider (48 shifts and the done
// flag) and saturates; then it computes the area and loads the result register,
// waiting there while the output register still holds a result not yet taken.
// Synchronous active-low reset clears control state and loads register defaults.
// A two-entry queue takes triangles, until it is full, while the back end works or the
// output stalls; a finished result waits in the output register.
`default_nettype none
module vertex_transform_project_cull (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire vtpc_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output vtpc_pkg::t_out      o_out_data
);
    vtpc_pkg::t_cfg r_cfg;
    logic           w_q_valid, w_q_ready;
    vtpc_pkg::t_in  w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x     <= 32'd0;
            r_cfg.offset_y     <= 32'd0;
            r_cfg.offset_z     <= 32'd0;
            r_cfg.model_yaw    <= 8'd0;
            r_cfg.camera_yaw   <= 8'd0;
            r_cfg.camera_pitch <= 8'd0;
            r_cfg.cull_enable  <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                vtpc_pkg::CFG_OFFSET_X:     r_cfg.offset_x     <= i_cfg_data;
                vtpc_pkg::CFG_OFFSET_Y:     r_cfg.offset_y     <= i_cfg_data;
                vtpc_pkg::CFG_OFFSET_Z:     r_cfg.offset_z     <= i_cfg_data;
                vtpc_pkg::CFG_MODEL_YAW:    r_cfg.model_yaw    <= i_cfg_data[7:0];
                vtpc_pkg::CFG_CAMERA_YAW:   r_cfg.camera_yaw   <= i_cfg_data[7:0];
                vtpc_pkg::CFG_CAMERA_PITCH: r_cfg.camera_pitch <= i_cfg_data[7:0];
                vtpc_pkg::CFG_CULL_ENABLE:  r_cfg.cull_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    vtpc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_q_valid),
        .i_q_ready  (w_q_ready),
        .o_q_data   (w_q_data)
    );

    vtpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_data    (w_q_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

@@ hdl/vtpc_front.sv @@
`default_nettype none
`include "vertex_transform_project_cull_assert.svh"
module vtpc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire vtpc_pkg::t_in i_in_data,
    output logic               o_q_valid,
    input  wire logic          i_q_ready,
    output vtpc_pkg::t_in      o_q_data
);
    vtpc_pkg::t_in r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_data   = r_mem[r_rp];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_in_data;
        end
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `VTPC_ASSERT(a_count_range, r_count != 2'd3, "queue count out of range")
    `VTPC_ASSERT_NEXT(a_full_push, (r_count == 2'd2) && !w_pop, !o_in_ready,
        "queue full but ready")
    `VTPC_ASSERT_NEXT(a_push_count, w_push && !w_pop && (r_count == 2'd0), r_count == 2'd1,
        "queue lost a transaction")
endmodule
`default_nettype wire

@@ hdl/vtpc_div.sv @@
`default_nettype none
module vtpc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_num_x,
    input  wire logic [47:0] i_num_y,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [47:0]      o_quo_x,
    output logic [47:0]      o_quo_y
);
    logic [47:0] r_qx, r_qy;
    logic [31:0] r_rx, r_ry, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_tx, w_ty;
    logic        w_gx, w_gy;

    assign w_tx = {r_rx, r_qx[47]};
    assign w_ty = {r_ry, r_qy[47]};
    assign w_gx = (w_tx >= {1'b0, r_den});
    assign w_gy = (w_ty >= {1'b0, r_den});
    assign o_done  = r_done;
    assign o_quo_x = r_qx;
    assign o_quo_y = r_qy;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_qx  <= i_num_x;
            r_qy  <= i_num_y;
            r_rx  <= 32'd0;
            r_ry  <= 32'd0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_qx <= {r_qx[46:0], w_gx};
            r_qy <= {r_qy[46:0], w_gy};
            r_rx <= w_gx ? 32'(w_tx - {1'b0, r_den}) : w_tx[31:0];
            r_ry <= w_gy ? 32'(w_ty - {1'b0, r_den}) : w_ty[31:0];
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(vtpc_pkg::DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/vtpc_back.sv @@
`default_nettype none
`include "vertex_transform_project_cull_assert.svh"
module vtpc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire vtpc_pkg::t_cfg i_cfg,
    input  wire logic           i_q_valid,
    output logic                o_q_ready,
    input  wire vtpc_pkg::t_in  i_q_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output vtpc_pkg::t_out      o_out_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DST, S_DIV, S_FIN, S_AREA, S_OUT
    } t_state;

    t_state         r_state;
    vtpc_pkg::t_in  r_item;
    vtpc_pkg::t_out r_out;
    logic           r_out_valid;
    logic [3:0]     r_step;
    logic [1:0]     r_vtx;
    logic           r_fail;
    logic [31:0]    r_t0, r_rx, r_ry, r_rz, r_cx, r_cy, r_cz, r_cz2, r_fx, r_fy;
    logic signed [15:0] r_sx [3];
    logic signed [15:0] r_sy [3];
    logic signed [33:0] r_prod;

    logic [31:0] w_x, w_y, w_z;
    logic [31:0] w_mc, w_ms, w_yc, w_ys, w_pc, w_ps;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic [31:0] w_fm;
    logic        w_div_start, w_div_done;
    logic [47:0] w_num_x, w_num_y, w_quo_x, w_quo_y;
    logic signed [48:0] w_qsx, w_qsy;
    logic signed [32:0] w_flx, w_fly;
    logic signed [33:0] w_sumx, w_sumy;
    logic signed [15:0] w_satx, w_saty;
    logic signed [16:0] w_d1, w_d2, w_d3, w_d4;
    logic signed [33:0] w_p2;
    logic signed [34:0] w_area;
    logic        w_out_free;

    assign w_mc = vtpc_pkg::cosine16(i_cfg.model_yaw);
    assign w_ms = vtpc_pkg::sine16(i_cfg.model_yaw);
    assign w_yc = vtpc_pkg::cosine16(i_cfg.camera_yaw);
    assign w_ys = vtpc_pkg::sine16(i_cfg.camera_yaw);
    assign w_pc = vtpc_pkg::cosine16(i_cfg.camera_pitch);
    assign w_ps = vtpc_pkg::sine16(i_cfg.camera_pitch);

    always_comb begin
        case (r_vtx)
            2'd0: begin
                w_x = r_item.a_x; w_y = r_item.a_y; w_z = r_item.a_z;
            end
            2'd1: begin
                w_x = r_item.b_x; w_y = r_item.b_y; w_z = r_item.b_z;
            end
            default: begin
                w_x = r_item.c_x; w_y = r_item.c_y; w_z = r_item.c_z;
            end
        endcase
    end

    always_comb begin
        case (r_step)
            4'd0:    begin w_ma = w_x;   w_mb = w_mc; end
            4'd1:    begin w_ma = w_z;   w_mb = w_ms; end
            4'd2:    begin w_ma = w_x;   w_mb = w_ms; end
            4'd3:    begin w_ma = w_z;   w_mb = w_mc; end
            4'd4:    begin w_ma = r_rx;  w_mb = w_yc; end
            4'd5:    begin w_ma = r_rz;  w_mb = w_ys; end
            4'd6:    begin w_ma = r_rx;  w_mb = w_ys; end
            4'd7:    begin w_ma = r_rz;  w_mb = w_yc; end
            4'd8:    begin w_ma = r_ry;  w_mb = w_pc; end
            4'd9:    begin w_ma = r_cz;  w_mb = w_ps; end
            4'd10:   begin w_ma = r_ry;  w_mb = w_ps; end
            4'd11:   begin w_ma = r_cz;  w_mb = w_pc; end
            4'd12:   begin w_ma = r_cx;  w_mb = vtpc_pkg::FOCAL_FIX; end
            default: begin w_ma = r_cy;  w_mb = vtpc_pkg::FOCAL_FIX; end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_fm   = w_prod[47:16];

    assign w_num_x = r_fx[31] ? (48'd0 - {r_fx, 16'd0}) : {r_fx, 16'd0};
    assign w_num_y = r_fy[31] ? (48'd0 - {r_fy, 16'd0}) : {r_fy, 16'd0};
    assign w_div_start = (r_state == S_DST);

    vtpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num_x (w_num_x),
        .i_num_y (w_num_y),
        .i_den   (r_cz2),
        .o_done  (w_div_done),
        .o_quo_x (w_quo_x),
        .o_quo_y (w_quo_y)
    );

    always_comb begin
        w_qsx  = r_fx[31] ? (49'sd0 - $signed({1'b0, w_quo_x})) : $signed({1'b0, w_quo_x});
        w_qsy  = r_fy[31] ? (49'sd0 - $signed({1'b0, w_quo_y})) : $signed({1'b0, w_quo_y});
        w_flx  = w_qsx[48:16];
        w_fly  = w_qsy[48:16];
        w_sumx = 34'sd160 + 34'(w_flx);
        w_sumy = 34'sd120 - 34'(w_fly);
        if (w_sumx > 34'sd32767) begin
            w_satx = 16'sh7FFF;
        end else if (w_sumx < -34'sd32768) begin
            w_satx = -16'sh8000;
        end else begin
            w_satx = w_sumx[15:0];
        end
        if (w_sumy > 34'sd32767) begin
            w_saty = 16'sh7FFF;
        end else if (w_sumy < -34'sd32768) begin
            w_saty = -16'sh8000;
        end else begin
            w_saty = w_sumy[15:0];
        end
    end

    assign w_d1   = 17'(r_sx[1]) - 17'(r_sx[0]);
    assign w_d2   = 17'(r_sy[2]) - 17'(r_sy[0]);
    assign w_d3   = 17'(r_sx[2]) - 17'(r_sx[0]);
    assign w_d4   = 17'(r_sy[1]) - 17'(r_sy[0]);
    assign w_p2   = w_d3 * w_d4;
    assign w_area = 35'(r_prod) - 35'(w_p2);

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_q_ready   = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= 4'd0;
            r_vtx       <= 2'd0;
            r_fail      <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_data;
                        r_step  <= 4'd0;
                        r_vtx   <= 2'd0;
                        r_fail  <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_step)
                        4'd0:  r_t0 <= w_fm;
                        4'd1:  r_rx <= r_t0 + w_fm + i_cfg.offset_x;
                        4'd2:  r_t0 <= w_fm;
                        4'd3: begin
                            r_rz <= w_fm - r_t0 + i_cfg.offset_z;
                            r_ry <= w_y + i_cfg.offset_y;
                        end
                        4'd4:  r_t0 <= w_fm;
                        4'd5:  r_cx <= r_t0 - w_fm;
                        4'd6:  r_t0 <= w_fm;
                        4'd7:  r_cz <= r_t0 + w_fm;
                        4'd8:  r_t0 <= w_fm;
                        4'd9:  r_cy <= r_t0 - w_fm;
                        4'd10: r_t0 <= w_fm;
                        4'd11: r_cz2 <= r_t0 + w_fm;
                        4'd12: r_fx <= w_fm;
                        default: r_fy <= w_fm;
                    endcase
                    if (r_step == 4'd13) begin
                        r_state <= S_DST;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_DST: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_sx[r_vtx] <= w_satx;
                    r_sy[r_vtx] <= w_saty;
                    if ($signed(r_cz2) <= vtpc_pkg::NEAR_Z) begin
                        r_fail <= 1'b1;
                    end
                    if (r_vtx == 2'd2) begin
                        r_state <= S_AREA;
                    end else begin
                        r_vtx   <= r_vtx + 2'd1;
                        r_step  <= 4'd0;
                        r_state <= S_MUL;
                    end
                end
                S_AREA: begin
                    r_prod  <= w_d1 * w_d2;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out.out_color   <= r_item.tri_color;
                        r_out.screen_x0   <= r_fail ? 16'sd0 : r_sx[0];
                        r_out.screen_y0   <= r_fail ? 16'sd0 : r_sy[0];
                        r_out.screen_x1   <= r_fail ? 16'sd0 : r_sx[1];
                        r_out.screen_y1   <= r_fail ? 16'sd0 : r_sy[1];
                        r_out.screen_x2   <= r_fail ? 16'sd0 : r_sx[2];
                        r_out.screen_y2   <= r_fail ? 16'sd0 : r_sy[2];
                        r_out.visible     <= !r_fail &&
                                             (!i_cfg.cull_enable || (w_area > 35'sd0));
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `VTPC_ASSERT(a_done_in_div, !w_div_done || (r_state == S_DIV), "divider done out of step")
    `VTPC_ASSERT(a_vtx_range, r_vtx != 2'd3, "vertex index out of range")
    `VTPC_ASSERT_NEXT(a_out_load, (r_state == S_OUT) && w_out_free, r_out_valid,
        "result not loaded")
endmodule
`default_nettype wire
